// ===== hw/rtl/swd_transfer_master_core_defines.svh =====
// Assertion macros for the SWD transfer master core.
`ifndef SWD_TRANSFER_MASTER_CORE_DEFINES_SVH
`define SWD_TRANSFER_MASTER_CORE_DEFINES_SVH

// Clocked check, muted while reset is held
`define SWD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers the reset cycles
`define SWD_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/swd_pkg.sv =====
// Shared types and codes for the SWD transfer master core.
`default_nettype none

package swd_pkg;

  localparam int DATA_BITS = 32;
  localparam int BIT_IDX_W = $clog2(DATA_BITS);
  localparam int CNT_W     = 6;
  localparam int PHASE_W   = 3;

  // Transfer phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REQ   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TRN1  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ACK   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RDATA = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DUMMY = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TRN2  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_WDATA = 3'd7;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Acknowledge patterns, first received bit in bit 0
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // Transfer status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_FAULT   = 3'd2;
  localparam logic [2:0] ST_ACK_ERR = 3'd3;
  localparam logic [2:0] ST_PAR_ERR = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_TURNAROUND = 2'd0;
  localparam logic [1:0] REG_DATA_PHASE = 2'd1;

  // Request latch bit positions
  localparam int RL_APNDP = 0;
  localparam int RL_RNW   = 1;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic [CNT_W-1:0]     bit_cnt;
    logic [DATA_BITS-1:0] data_shift;
    logic                 parity_acc;
    logic [2:0]           ack_reg;
    logic [3:0]           request_latch;
  } swd_state_t;

  typedef struct packed {
    logic [1:0] turnaround_extra;
    logic       data_phase_on_wait;
  } swd_cfg_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic                 ap_not_dp;
    logic [1:0]           addr_bits;
    logic [DATA_BITS-1:0] wr_word;
    logic                 swdio_in;
  } swd_item_t;

  typedef struct packed {
    logic                 swdio_out;
    logic                 swdio_drive;
    logic                 clock_pulse;
    logic                 busy_res;
    logic                 done_res;
    logic [2:0]           ack_bits;
    logic [2:0]           status;
    logic [DATA_BITS-1:0] rd_word;
  } swd_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swd_step.sv =====
// Next-state and per-period wire logic for one SWD clock period.
`default_nettype none

module swd_step (
  input  swd_pkg::swd_state_t  st,
  input  swd_pkg::swd_cfg_t    cfg,
  input  swd_pkg::swd_item_t   item,
  output swd_pkg::swd_state_t  st_next,
  output swd_pkg::swd_result_t res
);

  // Request header bit i: start, APnDP, RnW, A2, A3, parity, stop, park
  function automatic logic header_bit(input logic [3:0] rl, input logic [2:0] i);
    logic b;
    case (i)
      3'd0:    b = 1'b1;
      3'd1:    b = rl[0];
      3'd2:    b = rl[1];
      3'd3:    b = rl[2];
      3'd4:    b = rl[3];
      3'd5:    b = ^rl;
      3'd6:    b = 1'b0;
      default: b = 1'b1;
    endcase
    return b;
  endfunction

  swd_pkg::swd_state_t       cur;
  logic                      start;
  logic                      is_read;
  logic                      done;
  logic [swd_pkg::CNT_W-1:0] bc_inc;
  logic [swd_pkg::CNT_W-1:0] ta_lim;
  logic [swd_pkg::CNT_W-1:0] data_lim;
  logic [2:0]                ack_new;
  logic                      sout;
  logic                      wait_or_fault;

  always_comb begin
    // Start of a transfer is folded into this same period
    start = (st.phase == swd_pkg::PH_IDLE) &&
            (item.req_type == swd_pkg::REQ_READ || item.req_type == swd_pkg::REQ_WRITE);
    cur = st;
    if (start) begin
      cur.phase         = swd_pkg::PH_REQ;
      cur.request_latch = {item.addr_bits, (item.req_type == swd_pkg::REQ_READ),
                           item.ap_not_dp};
      cur.data_shift    = (item.req_type == swd_pkg::REQ_WRITE) ? item.wr_word : '0;
      cur.parity_acc    = 1'b0;
      cur.ack_reg       = 3'b000;
      cur.bit_cnt       = '0;
    end

    st_next  = cur;
    is_read  = cur.request_latch[swd_pkg::RL_RNW];
    bc_inc   = cur.bit_cnt + swd_pkg::CNT_W'(1);
    ta_lim   = swd_pkg::CNT_W'(cfg.turnaround_extra);
    data_lim = swd_pkg::CNT_W'(swd_pkg::DATA_BITS);
    ack_new  = cur.ack_reg | (3'({2'b00, item.swdio_in}) << cur.bit_cnt[1:0]);
    done     = 1'b0;
    sout     = 1'b1;
    wait_or_fault = 1'b0;

    res.swdio_out   = 1'b1;
    res.swdio_drive = 1'b1;
    res.clock_pulse = 1'b1;

    unique case (cur.phase)
      swd_pkg::PH_REQ: begin
        sout = header_bit(cur.request_latch, cur.bit_cnt[2:0]);
        st_next.bit_cnt = bc_inc;
        if (bc_inc >= swd_pkg::CNT_W'(8)) begin
          st_next.phase   = swd_pkg::PH_TRN1;
          st_next.bit_cnt = '0;
        end
      end
      swd_pkg::PH_TRN1: begin
        sout = 1'b0;
        res.swdio_drive = 1'b0;
        st_next.bit_cnt = bc_inc;
        if (bc_inc > ta_lim) begin
          st_next.phase   = swd_pkg::PH_ACK;
          st_next.bit_cnt = '0;
        end
      end
      swd_pkg::PH_ACK: begin
        sout = 1'b0;
        res.swdio_drive = 1'b0;
        st_next.ack_reg = ack_new;
        st_next.bit_cnt = bc_inc;
        wait_or_fault = (ack_new == swd_pkg::ACK_WAIT) || (ack_new == swd_pkg::ACK_FAULT);
        if (bc_inc >= swd_pkg::CNT_W'(3)) begin
          st_next.bit_cnt = '0;
          if (!is_read) begin
            st_next.phase = swd_pkg::PH_TRN2;
          end else if (ack_new == swd_pkg::ACK_OK) begin
            st_next.phase = swd_pkg::PH_RDATA;
          end else if (wait_or_fault) begin
            st_next.phase = cfg.data_phase_on_wait ? swd_pkg::PH_DUMMY : swd_pkg::PH_TRN2;
          end else begin
            done = 1'b1;
          end
        end
      end
      swd_pkg::PH_RDATA: begin
        sout = 1'b0;
        res.swdio_drive = 1'b0;
        if (cur.bit_cnt < data_lim) begin
          st_next.data_shift[cur.bit_cnt[swd_pkg::BIT_IDX_W-1:0]] =
            cur.data_shift[cur.bit_cnt[swd_pkg::BIT_IDX_W-1:0]] | item.swdio_in;
        end
        st_next.parity_acc = cur.parity_acc ^ item.swdio_in;
        st_next.bit_cnt    = bc_inc;
        if (bc_inc > data_lim) begin
          st_next.phase   = swd_pkg::PH_TRN2;
          st_next.bit_cnt = '0;
        end
      end
      swd_pkg::PH_DUMMY: begin
        sout = 1'b0;
        res.swdio_drive = 1'b0;
        st_next.bit_cnt = bc_inc;
        if (bc_inc > data_lim) begin
          st_next.phase   = swd_pkg::PH_TRN2;
          st_next.bit_cnt = '0;
        end
      end
      swd_pkg::PH_TRN2: begin
        sout = 1'b0;
        res.swdio_drive = 1'b0;
        st_next.bit_cnt = bc_inc;
        wait_or_fault = (cur.ack_reg == swd_pkg::ACK_WAIT) ||
                        (cur.ack_reg == swd_pkg::ACK_FAULT);
        if (bc_inc > ta_lim) begin
          st_next.bit_cnt = '0;
          if (is_read) begin
            done = 1'b1;
          end else if (cur.ack_reg == swd_pkg::ACK_OK) begin
            st_next.phase      = swd_pkg::PH_WDATA;
            st_next.parity_acc = 1'b0;
          end else if (wait_or_fault) begin
            // WAIT or FAULT on a write: send zeros with zero parity
            st_next.phase      = swd_pkg::PH_WDATA;
            st_next.parity_acc = 1'b0;
            st_next.data_shift = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      swd_pkg::PH_WDATA: begin
        if (cur.bit_cnt < data_lim) begin
          sout = cur.data_shift[cur.bit_cnt[swd_pkg::BIT_IDX_W-1:0]];
          st_next.parity_acc = cur.parity_acc ^ sout;
        end else begin
          sout = cur.parity_acc;
        end
        st_next.bit_cnt = bc_inc;
        if (bc_inc > data_lim) begin
          done = 1'b1;
        end
      end
      default: begin
        // idle: no clock, line held high
        res.clock_pulse = 1'b0;
      end
    endcase

    res.swdio_out = sout;
    res.done_res  = done;
    res.ack_bits  = 3'b000;
    res.status    = swd_pkg::ST_OK;
    res.rd_word   = '0;

    // End of transfer: report and return to idle
    if (done) begin
      unique case (st_next.ack_reg)
        swd_pkg::ACK_OK:    res.status = swd_pkg::ST_OK;
        swd_pkg::ACK_WAIT:  res.status = swd_pkg::ST_WAIT;
        swd_pkg::ACK_FAULT: res.status = swd_pkg::ST_FAULT;
        default:            res.status = swd_pkg::ST_ACK_ERR;
      endcase
      if (is_read && st_next.ack_reg == swd_pkg::ACK_OK) begin
        res.rd_word = st_next.data_shift;
        if (st_next.parity_acc) begin
          res.status = swd_pkg::ST_PAR_ERR;
        end
      end
      res.ack_bits    = st_next.ack_reg;
      st_next.phase   = swd_pkg::PH_IDLE;
      st_next.bit_cnt = '0;
    end

    res.busy_res = (st_next.phase != swd_pkg::PH_IDLE);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swd_transfer_master_core.sv =====
// Top level of the SWD transfer master core: beat registers, config and state.
//
//   channel | direction | handshake         | beat
//   --------+-----------+-------------------+--------------------------------------
//   in      | sink      | in_valid/in_stall | one SWD period: request, data, SWDIO
//   out     | source    | out_valid/out_stall | SWDIO level, drive, clock, status
//   cfg     | sink      | cfg_valid/cfg_ready | register index and write data
//
// An accepted in beat sits in the in register until the out register can take it.
// One beat per cycle while out is not stalled; the transfer state updates once per beat.
// A stalled out register holds the in register, which then raises in_stall.
// Synchronous reset returns to idle with no beats held; cfg_ready is always high.
`default_nettype none
`include "swd_transfer_master_core_defines.svh"

module swd_transfer_master_core (
  input  logic                          clk,
  input  logic                          rst,
  // input beat channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic                          ap_not_dp,
  input  logic [1:0]                    addr_bits,
  input  logic [swd_pkg::DATA_BITS-1:0] wr_word,
  input  logic                          swdio_in,
  // result beat channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          swdio_out,
  output logic                          swdio_drive,
  output logic                          clock_pulse,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [2:0]                    ack_bits,
  output logic [2:0]                    status,
  output logic [swd_pkg::DATA_BITS-1:0] rd_word,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [1:0]                    cfg_data
);

  logic                 s1_valid;
  swd_pkg::swd_item_t   s1_item;
  swd_pkg::swd_state_t  state;
  swd_pkg::swd_state_t  state_next;
  swd_pkg::swd_cfg_t    cfg;
  swd_pkg::swd_result_t res_next;
  swd_pkg::swd_result_t res;
  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;

  // Handshake flow
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= '{req_type: req_type, ap_not_dp: ap_not_dp, addr_bits: addr_bits,
                   wr_word: wr_word, swdio_in: swdio_in};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swd_pkg::REG_TURNAROUND: cfg.turnaround_extra   <= cfg_data;
        swd_pkg::REG_DATA_PHASE: cfg.data_phase_on_wait <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-period transfer logic
  swd_step u_step (
    .st      (state),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (state_next),
    .res     (res_next)
  );

  // Transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign swdio_out   = res.swdio_out;
  assign swdio_drive = res.swdio_drive;
  assign clock_pulse = res.clock_pulse;
  assign busy_res    = res.busy_res;
  assign done_res    = res.done_res;
  assign ack_bits    = res.ack_bits;
  assign status      = res.status;
  assign rd_word     = res.rd_word;

  // Checks
  `SWD_CHECK(a_done_not_busy, out_valid && done_res |-> !busy_res, "done with busy set")
  `SWD_CHECK(a_status_only_done,
             out_valid && !done_res |-> status == swd_pkg::ST_OK && ack_bits == 3'b000,
             "status outside done")
  `SWD_CHECK(a_idle_count_zero,
             state.phase == swd_pkg::PH_IDLE |-> state.bit_cnt == '0,
             "count left over at idle")
  `SWD_CHECK(a_stall_needs_beat, in_stall |-> s1_valid, "stall with empty input register")
  `SWD_CHECK_RST(a_reset_empty, rst |=> !out_valid && !s1_valid, "beat survives reset")

endmodule

`default_nettype wire

// ===== tb/swd_transfer_checker.sv =====
// Checker for the SWD transfer master: predicts each result beat and compares it.
`default_nettype none

module swd_transfer_checker
  import swd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic                 ap_not_dp,
  input  logic [1:0]           addr_bits,
  input  logic [DATA_BITS-1:0] wr_word,
  input  logic                 swdio_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 swdio_out,
  input  logic                 swdio_drive,
  input  logic                 clock_pulse,
  input  logic                 busy_res,
  input  logic                 done_res,
  input  logic [2:0]           ack_bits,
  input  logic [2:0]           status,
  input  logic [DATA_BITS-1:0] rd_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [1:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [CNT_W-1:0] HEADER_BITS = CNT_W'(8);
  localparam logic [CNT_W-1:0] ACK_BITS    = CNT_W'(3);
  localparam logic [CNT_W-1:0] WORD_BITS   = CNT_W'(DATA_BITS);
  localparam logic [CNT_W-1:0] ONE         = CNT_W'(1);

  // shadow of the engine state and its registers
  swd_state_t  link;
  swd_cfg_t    regs;
  swd_result_t expected_periods[$];
  int          mismatches;
  int          results_seen;

  // one SWCLK period of the transfer engine
  function automatic swd_result_t advance_period(input swd_item_t it);
    swd_result_t r;
    logic        rd;
    logic        finish;
    logic [7:0]  header;
    logic [2:0]  code;
    r = '0;
    r.swdio_out   = 1'b1;
    r.swdio_drive = 1'b1;
    r.clock_pulse = 1'b1;
    finish = 1'b0;

    // a request only starts from idle
    if (link.phase == PH_IDLE && (it.req_type == REQ_READ || it.req_type == REQ_WRITE)) begin
      link.request_latch = {it.addr_bits, it.req_type == REQ_READ, it.ap_not_dp};
      link.data_shift    = (it.req_type == REQ_WRITE) ? it.wr_word : '0;
      link.parity_acc    = 1'b0;
      link.ack_reg       = '0;
      link.bit_cnt       = '0;
      link.phase         = PH_REQ;
    end
    rd = link.request_latch[RL_RNW];
    // start, APnDP, RnW, A2, A3, parity, stop, park (bit 0 goes out first)
    header = {1'b1, 1'b0, ^link.request_latch, link.request_latch[3:2],
              link.request_latch[RL_RNW], link.request_latch[RL_APNDP], 1'b1};

    case (link.phase)
      PH_REQ: begin
        r.swdio_out = header[link.bit_cnt[2:0]];
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt >= HEADER_BITS) begin
          link.phase = PH_TRN1;
          link.bit_cnt = '0;
        end
      end
      PH_TRN1: begin
        r.swdio_out = 1'b0;
        r.swdio_drive = 1'b0;
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt > CNT_W'(regs.turnaround_extra)) begin
          link.phase = PH_ACK;
          link.bit_cnt = '0;
        end
      end
      PH_ACK: begin
        r.swdio_out = 1'b0;
        r.swdio_drive = 1'b0;
        link.ack_reg = link.ack_reg | (3'(it.swdio_in) << link.bit_cnt[1:0]);
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt >= ACK_BITS) begin
          link.bit_cnt = '0;
          if (!rd)
            link.phase = PH_TRN2;
          else if (link.ack_reg == ACK_OK)
            link.phase = PH_RDATA;
          else if (link.ack_reg == ACK_WAIT || link.ack_reg == ACK_FAULT)
            link.phase = regs.data_phase_on_wait ? PH_DUMMY : PH_TRN2;
          else
            finish = 1'b1;
        end
      end
      PH_RDATA: begin
        r.swdio_out = 1'b0;
        r.swdio_drive = 1'b0;
        if (link.bit_cnt < WORD_BITS)
          link.data_shift[link.bit_cnt[BIT_IDX_W-1:0]] =
            link.data_shift[link.bit_cnt[BIT_IDX_W-1:0]] | it.swdio_in;
        link.parity_acc = link.parity_acc ^ it.swdio_in;
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt > WORD_BITS) begin
          link.phase = PH_TRN2;
          link.bit_cnt = '0;
        end
      end
      PH_DUMMY: begin
        r.swdio_out = 1'b0;
        r.swdio_drive = 1'b0;
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt > WORD_BITS) begin
          link.phase = PH_TRN2;
          link.bit_cnt = '0;
        end
      end
      PH_TRN2: begin
        r.swdio_out = 1'b0;
        r.swdio_drive = 1'b0;
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt > CNT_W'(regs.turnaround_extra)) begin
          link.bit_cnt = '0;
          if (rd) begin
            finish = 1'b1;
          end else if (link.ack_reg == ACK_OK) begin
            link.phase = PH_WDATA;
            link.parity_acc = 1'b0;
          end else if (link.ack_reg == ACK_WAIT || link.ack_reg == ACK_FAULT) begin
            // WAIT/FAULT write still clocks a zero data phase
            link.phase = PH_WDATA;
            link.parity_acc = 1'b0;
            link.data_shift = '0;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_WDATA: begin
        if (link.bit_cnt < WORD_BITS) begin
          r.swdio_out = link.data_shift[link.bit_cnt[BIT_IDX_W-1:0]];
          link.parity_acc = link.parity_acc ^ r.swdio_out;
        end else begin
          r.swdio_out = link.parity_acc;
        end
        link.bit_cnt = link.bit_cnt + ONE;
        if (link.bit_cnt > WORD_BITS)
          finish = 1'b1;
      end
      default: begin
        r.clock_pulse = 1'b0;
      end
    endcase

    // end of transfer: report ack, status and read word
    if (finish) begin
      case (link.ack_reg)
        ACK_OK:    code = ST_OK;
        ACK_WAIT:  code = ST_WAIT;
        ACK_FAULT: code = ST_FAULT;
        default:   code = ST_ACK_ERR;
      endcase
      if (rd && code == ST_OK && link.parity_acc)
        code = ST_PAR_ERR;
      r.done_res = 1'b1;
      r.status   = code;
      r.ack_bits = link.ack_reg;
      if (rd && link.ack_reg == ACK_OK)
        r.rd_word = link.data_shift;
      link.phase = PH_IDLE;
      link.bit_cnt = '0;
    end
    r.busy_res = (link.phase != PH_IDLE);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d: %s expected %h, got %h",
                 results_seen, name, want_v, got_v);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin : watch
    swd_item_t   it;
    swd_result_t got;
    swd_result_t want;
    if (rst) begin
      link = '0;
      regs = '0;
      expected_periods.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        got = {swdio_out, swdio_drive, clock_pulse, busy_res, done_res,
               ack_bits, status, rd_word};
        if (expected_periods.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with none predicted", results_seen);
        end else begin
          want = expected_periods.pop_front();
          compare_field("swdio_out", want.swdio_out, got.swdio_out);
          compare_field("swdio_drive", want.swdio_drive, got.swdio_drive);
          compare_field("clock_pulse", want.clock_pulse, got.clock_pulse);
          compare_field("busy_res", want.busy_res, got.busy_res);
          compare_field("done_res", want.done_res, got.done_res);
          compare_field("ack_bits", want.ack_bits, got.ack_bits);
          compare_field("status", want.status, got.status);
          compare_field("rd_word", want.rd_word, got.rd_word);
        end
        results_seen++;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TURNAROUND: regs.turnaround_extra = cfg_data;
          REG_DATA_PHASE: regs.data_phase_on_wait = cfg_data[0];
          default: ;
        endcase
      end
      // input beat: predict its result
      if (in_valid && !in_stall) begin
        it = {req_type, ap_not_dp, addr_bits, wr_word, swdio_in};
        expected_periods.push_back(advance_period(it));
      end
    end
    pending    <= expected_periods.size();
    fail_count <= mismatches;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the SWD transfer master: stimulus, idling, watchdog and verdict.
`default_nettype none

module tb_top;
  import swd_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [2:0] ACK_NONE    = 3'b000;
  localparam logic [2:0] ACK_ALL     = 3'b111;
  localparam int         HOLD_CYCLES = 400;
  localparam int         STUCK_LIMIT = 3000;
  localparam int         SEG_BEATS   = 130;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           req_type;
  logic                 ap_not_dp;
  logic [1:0]           addr_bits;
  logic [DATA_BITS-1:0] wr_word;
  logic                 swdio_in;
  logic                 out_valid;
  logic                 out_stall;
  logic                 swdio_out;
  logic                 swdio_drive;
  logic                 clock_pulse;
  logic                 busy_res;
  logic                 done_res;
  logic [2:0]           ack_bits;
  logic [2:0]           status;
  logic [DATA_BITS-1:0] rd_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [1:0]           cfg_data;
  int                   fail_count;
  int                   pending;

  // stimulus side knowledge of the settings, for transfer timing only
  logic [1:0] ta_now;
  logic       dp_now;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_seq;
  int         hold_seen;
  int         beats_sent;
  int         stuck;
  int         ta_plan [6] = '{3, 1, 0, 2, 3, 0};
  int         dp_plan [6] = '{1, 0, 1, 0, 0, 1};

  swd_transfer_master_core dut (.*);
  swd_transfer_checker     u_check (.*);

  always #10 clk = ~clk;

  // one input beat, with random gaps ahead of it
  task automatic put_beat(input logic [1:0] rq, input logic ap, input logic [1:0] ad,
                          input logic [31:0] wd, input logic din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    ap_not_dp <= ap;
    addr_bits <= ad;
    wr_word   <= wd;
    swdio_in  <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // beat inside a transfer: request fields are noise the engine must ignore
  task automatic busy_beat(input logic din);
    put_beat(2'($urandom_range(3)), 1'($urandom_range(1)), 2'($urandom_range(3)),
             $urandom, din);
  endtask

  // a complete transfer, timed from the current settings
  task automatic run_transfer(input logic rd, input logic [2:0] ack);
    logic [31:0] word;
    logic        par;
    put_beat(rd ? REQ_READ : REQ_WRITE, 1'($urandom_range(1)), 2'($urandom_range(3)),
             $urandom, 1'($urandom_range(1)));
    // rest of the header and the first turnaround
    repeat (7 + ta_now + 1) busy_beat(1'($urandom_range(1)));
    for (int i = 0; i < 3; i++) busy_beat(ack[i]);
    if (rd) begin
      if (ack == ACK_OK) begin
        word = $urandom;
        // mostly good parity, sometimes flipped
        par = ^word ^ ($urandom_range(4) == 0);
        for (int i = 0; i < DATA_BITS; i++) busy_beat(word[i]);
        busy_beat(par);
        repeat (ta_now + 1) busy_beat(1'($urandom_range(1)));
      end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
        repeat ((dp_now ? DATA_BITS + 1 : 0) + ta_now + 1) busy_beat(1'($urandom_range(1)));
      end
    end else begin
      repeat (ta_now + 1) busy_beat(1'($urandom_range(1)));
      if (ack == ACK_OK || ack == ACK_WAIT || ack == ACK_FAULT)
        repeat (DATA_BITS + 1) busy_beat(1'($urandom_range(1)));
    end
  endtask

  // stop sending and let every predicted result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // both registers, back to back on the config channel
  task automatic set_config(input logic [1:0] ta, input logic dp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TURNAROUND;
    cfg_data  <= ta;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_DATA_PHASE;
    cfg_data  <= {1'b0, dp};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ta_now = ta;
    dp_now = dp;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // main stimulus
  initial begin
    int          pick;
    logic [2:0]  ack;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_TICK;
    ap_not_dp  <= 1'b0;
    addr_bits  <= '0;
    wr_word    <= '0;
    swdio_in   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_TURNAROUND;
    cfg_data   <= '0;
    hold_seq   <= 0;
    recv_idle_pct <= 0;
    send_idle_pct = 0;
    beats_sent = 0;
    ta_now = '0;
    dp_now = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes on ticks, unused code, invalid acks both ways
    put_beat(REQ_TICK, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1);
    put_beat(REQ_UNUSED, 1'b0, 2'd0, 32'h0, 1'b0);
    run_transfer(1'b1, ACK_NONE);
    run_transfer(1'b0, ACK_ALL);

    // random segments, each under its own settings; idling mode changes every two segments
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      send_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 88 : 0;
      recv_idle_pct <= (seg < 2) ? 88 : (seg < 4) ? 14 : 0;
      if (seg == 5)
        set_config(2'($urandom_range(3)), 1'($urandom_range(1)));
      else
        set_config(2'(ta_plan[seg]), 1'(dp_plan[seg]));
      // long receiver hold while the sender keeps offering
      if (seg == 4)
        hold_seq <= hold_seq + 1;
      pick = beats_sent + SEG_BEATS;
      while (beats_sent < pick) begin
        repeat ($urandom_range(3))
          put_beat($urandom_range(1) ? REQ_TICK : REQ_UNUSED, 1'($urandom_range(1)),
                   2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
        case ($urandom_range(3))
          0: ack = 3'($urandom_range(7));
          1: ack = ($urandom_range(1) != 0) ? ACK_WAIT : ACK_FAULT;
          default: ack = ACK_OK;
        endcase
        run_transfer(1'($urandom_range(1)), ack);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/swd_pkg.sv
hw/rtl/swd_step.sv
hw/rtl/swd_transfer_master_core.sv
tb/swd_transfer_checker.sv
tb/tb_top.sv
